>>> design/jtl_pkg.sv
// Shared widths, token kind codes and result types for the JSON token lexer.
package jtl_pkg;

    localparam int POS_W            = 20;
    localparam int LEN_W            = POS_W + 1;
    localparam int MAX_SOURCE_BYTES = 2 ** POS_W;
    localparam int KIND_W           = 4;

    localparam logic [KIND_W-1:0] K_LBRACE = 4'd0;
    localparam logic [KIND_W-1:0] K_RBRACE = 4'd1;
    localparam logic [KIND_W-1:0] K_LBRACK = 4'd2;
    localparam logic [KIND_W-1:0] K_RBRACK = 4'd3;
    localparam logic [KIND_W-1:0] K_COLON  = 4'd4;
    localparam logic [KIND_W-1:0] K_COMMA  = 4'd5;
    localparam logic [KIND_W-1:0] K_STRING = 4'd6;
    localparam logic [KIND_W-1:0] K_NUMBER = 4'd7;
    localparam logic [KIND_W-1:0] K_TRUE   = 4'd8;
    localparam logic [KIND_W-1:0] K_END    = 4'd11;
    localparam logic [KIND_W-1:0] K_ERROR  = 4'd12;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  offset;
        logic [LEN_W-1:0]  length;
        logic              last;
    } t_tok;

    typedef struct packed {
        t_tok [2:0]  tok;
        logic [1:0]  cnt;
    } t_batch;

endpackage

>>> design/jtl_ifs.sv
// Valid/ready channel interfaces for source bytes and result tokens.
interface jtl_src_if;
    logic       valid;
    logic       ready;
    logic [7:0] source_byte;
    logic       final_byte;

    modport source (output valid, output source_byte, output final_byte, input ready);
    modport sink   (input valid, input source_byte, input final_byte, output ready);
endinterface

interface jtl_tok_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [19:0] token_offset;
    logic [20:0] token_length;
    logic        run_last;

    modport source (output valid, output token_kind, output token_offset,
                    output token_length, output run_last, input ready);
    modport sink   (input valid, input token_kind, input token_offset,
                    input token_length, input run_last, output ready);
endinterface

>>> design/jtl_scan.sv
// Lexer state registers and per-byte next-state and token logic.
module jtl_scan import jtl_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_adv,
    input  logic [7:0] i_byte,
    input  logic       i_fin,
    output t_batch     o_batch
);

    localparam logic [3:0] M_IDLE     = 4'd0;
    localparam logic [3:0] M_STR      = 4'd1;
    localparam logic [3:0] M_ESC      = 4'd2;
    localparam logic [3:0] M_HEX      = 4'd3;
    localparam logic [3:0] M_SIGN     = 4'd4;
    localparam logic [3:0] M_DOT      = 4'd5;
    localparam logic [3:0] M_INT      = 4'd6;
    localparam logic [3:0] M_FRACNEED = 4'd7;
    localparam logic [3:0] M_FRAC     = 4'd8;
    localparam logic [3:0] M_EXP      = 4'd9;
    localparam logic [3:0] M_EXPSIGN  = 4'd10;
    localparam logic [3:0] M_EXPDIG   = 4'd11;
    localparam logic [3:0] M_LIT      = 4'd12;
    localparam logic [3:0] M_ERR      = 4'd13;

    localparam logic [1:0] L_TRUE  = 2'd0;
    localparam logic [1:0] L_FALSE = 2'd1;
    localparam logic [1:0] L_NULL  = 2'd2;

    function automatic t_tok mk_tok(logic [KIND_W-1:0] k, logic [POS_W-1:0] o,
                                    logic [LEN_W-1:0] l);
        t_tok t;
        t.kind   = k;
        t.offset = o;
        t.length = l;
        t.last   = 1'b0;
        return t;
    endfunction

    function automatic logic [7:0] lit_char(logic [1:0] w, logic [1:0] idx);
        logic [7:0] ch;
        case ({w, idx})
            {L_TRUE, 2'd0}:  ch = "r";
            {L_TRUE, 2'd1}:  ch = "u";
            {L_TRUE, 2'd2}:  ch = "e";
            {L_FALSE, 2'd0}: ch = "a";
            {L_FALSE, 2'd1}: ch = "l";
            {L_FALSE, 2'd2}: ch = "s";
            {L_FALSE, 2'd3}: ch = "e";
            {L_NULL, 2'd0}:  ch = "u";
            {L_NULL, 2'd1}:  ch = "l";
            {L_NULL, 2'd2}:  ch = "l";
            default:         ch = 8'h00;
        endcase
        return ch;
    endfunction

    logic [3:0]       r_mode, n_mode;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [POS_W-1:0] r_start, n_start;
    logic [1:0]       r_hex, n_hex;
    logic [1:0]       r_lidx, n_lidx;
    logic [1:0]       r_lwh, n_lwh;

    always_comb begin
        logic             fin, dig, hexc, is_e, esc_ok, lit_hit;
        logic [1:0]       w;
        logic [2:0]       llen;
        logic [2:0]       lidx_inc;
        logic [3:0]       id_mode;
        logic             id_start, id_emit;
        t_tok             id_tok;
        logic [1:0]       id_wh;
        logic [LEN_W-1:0] len_ps, span;
        logic [3:0]       m1;
        logic [POS_W-1:0] s1;
        logic [1:0]       hex1, lidx1, lwh1;
        logic [1:0]       st_n, fl_n;
        t_tok             st0, st1, fl0, fl1;
        logic             end_num;
        t_tok             res0, res1, res2;
        logic [1:0]       cnt;

        fin    = i_fin || (r_pos == POS_W'(MAX_SOURCE_BYTES - 1));
        dig    = (i_byte >= "0") && (i_byte <= "9");
        hexc   = dig || ((i_byte >= "a") && (i_byte <= "f"))
                     || ((i_byte >= "A") && (i_byte <= "F"));
        is_e   = (i_byte == "e") || (i_byte == "E");
        esc_ok = (i_byte == 8'h22) || (i_byte == 8'h5C) || (i_byte == "/")
              || (i_byte == "b") || (i_byte == "f") || (i_byte == "n")
              || (i_byte == "r") || (i_byte == "t");
        len_ps = {1'b0, r_pos} - {1'b0, r_start};

        // decode of a byte seen between tokens
        id_mode  = M_IDLE;
        id_start = 1'b0;
        id_emit  = 1'b0;
        id_wh    = L_TRUE;
        id_tok   = mk_tok(K_ERROR, r_pos, LEN_W'(1));
        case (i_byte) inside
            8'h20, 8'h09, 8'h0D, 8'h0A: ;
            "{": begin id_emit = 1'b1; id_tok.kind = K_LBRACE; end
            "}": begin id_emit = 1'b1; id_tok.kind = K_RBRACE; end
            "[": begin id_emit = 1'b1; id_tok.kind = K_LBRACK; end
            "]": begin id_emit = 1'b1; id_tok.kind = K_RBRACK; end
            ":": begin id_emit = 1'b1; id_tok.kind = K_COLON; end
            ",": begin id_emit = 1'b1; id_tok.kind = K_COMMA; end
            8'h22: begin id_mode = M_STR; id_start = 1'b1; end
            "-", "+": begin id_mode = M_SIGN; id_start = 1'b1; end
            ".": begin id_mode = M_DOT; id_start = 1'b1; end
            "t": begin id_mode = M_LIT; id_start = 1'b1; id_wh = L_TRUE; end
            "f": begin id_mode = M_LIT; id_start = 1'b1; id_wh = L_FALSE; end
            "n": begin id_mode = M_LIT; id_start = 1'b1; id_wh = L_NULL; end
            [8'h30:8'h39]: begin id_mode = M_INT; id_start = 1'b1; end
            default: begin id_emit = 1'b1; id_mode = M_ERR; end
        endcase

        w        = (r_lwh == 2'd3) ? L_TRUE : r_lwh;
        llen     = (w == L_FALSE) ? 3'd4 : 3'd3;
        lidx_inc = {1'b0, r_lidx} + 3'd1;
        lit_hit  = ({1'b0, r_lidx} < llen) && (i_byte == lit_char(w, r_lidx));

        m1      = r_mode;
        s1      = r_start;
        hex1    = r_hex;
        lidx1   = r_lidx;
        lwh1    = r_lwh;
        st_n    = 2'd0;
        st0     = mk_tok(K_ERROR, r_start, len_ps);
        st1     = id_tok;
        end_num = 1'b0;

        unique case (r_mode)
            M_STR: begin
                if (i_byte == 8'h22) begin
                    st_n = 2'd1;
                    st0  = mk_tok(K_STRING, r_start + POS_W'(1), len_ps - LEN_W'(1));
                    m1   = M_IDLE;
                end else if (i_byte == 8'h5C) begin
                    m1 = M_ESC;
                end else if (i_byte < 8'd32) begin
                    st_n = 2'd1;
                    m1   = M_ERR;
                end
            end
            M_ESC: begin
                if (i_byte == "u") begin
                    m1   = M_HEX;
                    hex1 = 2'd0;
                end else if (esc_ok) begin
                    m1 = M_STR;
                end else begin
                    st_n = 2'd1;
                    m1   = M_ERR;
                end
            end
            M_HEX: begin
                if (hexc) begin
                    hex1 = r_hex + 2'd1;
                    if (r_hex == 2'd3) m1 = M_STR;
                end else begin
                    st_n = 2'd1;
                    m1   = M_ERR;
                end
            end
            M_SIGN, M_DOT: begin
                if (dig) begin
                    m1 = (r_mode == M_SIGN) ? M_INT : M_FRAC;
                end else begin
                    st_n = 2'd1;
                    st0  = mk_tok(K_ERROR, r_start, LEN_W'(1));
                    m1   = M_ERR;
                end
            end
            M_INT: begin
                if (!dig) begin
                    if (i_byte == ".") m1 = M_FRACNEED;
                    else if (is_e) m1 = M_EXP;
                    else end_num = 1'b1;
                end
            end
            M_FRACNEED, M_EXPSIGN: begin
                if (dig) begin
                    m1 = (r_mode == M_FRACNEED) ? M_FRAC : M_EXPDIG;
                end else begin
                    st_n = 2'd1;
                    m1   = M_ERR;
                end
            end
            M_FRAC: begin
                if (!dig) begin
                    if (is_e) m1 = M_EXP;
                    else end_num = 1'b1;
                end
            end
            M_EXP: begin
                if (i_byte == "+" || i_byte == "-") begin
                    m1 = M_EXPSIGN;
                end else if (dig) begin
                    m1 = M_EXPDIG;
                end else begin
                    st_n = 2'd1;
                    m1   = M_ERR;
                end
            end
            M_EXPDIG: begin
                if (!dig) end_num = 1'b1;
            end
            M_LIT: begin
                if (lit_hit) begin
                    lidx1 = lidx_inc[1:0];
                    if (lidx_inc >= llen) begin
                        st_n  = 2'd1;
                        st0   = mk_tok(K_TRUE + KIND_W'(w), '0, '0);
                        m1    = M_IDLE;
                        lidx1 = 2'd0;
                    end
                end else begin
                    st_n = 2'd1;
                    st0  = mk_tok(K_ERROR, r_start, LEN_W'(1));
                    m1   = M_ERR;
                end
            end
            M_ERR: ;
            default: begin
                st_n = {1'b0, id_emit};
                st0  = id_tok;
                m1   = id_mode;
                if (id_start) begin
                    s1    = r_pos;
                    lidx1 = 2'd0;
                    lwh1  = (id_mode == M_LIT) ? id_wh : r_lwh;
                end
            end
        endcase

        if (end_num) begin
            st_n = id_emit ? 2'd2 : 2'd1;
            st0  = mk_tok(K_NUMBER, r_start, len_ps);
            m1   = id_mode;
            if (id_start) begin
                s1    = r_pos;
                lidx1 = 2'd0;
                lwh1  = (id_mode == M_LIT) ? id_wh : r_lwh;
            end
        end

        // flush at the final byte
        span = {1'b0, r_pos} + LEN_W'(1) - {1'b0, s1};
        fl_n = 2'd0;
        fl0  = mk_tok(K_END, '0, '0);
        fl1  = mk_tok(K_END, '0, '0);
        if (fin) begin
            case (m1) inside
                M_IDLE: fl_n = 2'd1;
                M_INT, M_FRAC, M_EXPDIG: begin
                    fl_n = 2'd2;
                    fl0  = mk_tok(K_NUMBER, s1, span);
                end
                M_STR, M_ESC, M_HEX, M_FRACNEED, M_EXP, M_EXPSIGN: begin
                    fl_n = 2'd1;
                    fl0  = mk_tok(K_ERROR, s1, span);
                end
                M_SIGN, M_DOT, M_LIT: begin
                    fl_n = 2'd1;
                    fl0  = mk_tok(K_ERROR, s1, LEN_W'(1));
                end
                default: fl_n = 2'd0;
            endcase
        end

        cnt  = st_n + fl_n;
        res0 = (st_n != 2'd0) ? st0 : fl0;
        res1 = (st_n == 2'd2) ? st1 : (st_n == 2'd1) ? fl0 : fl1;
        res2 = (st_n == 2'd2) ? fl0 : fl1;
        res0.last = (cnt == 2'd1);
        res1.last = (cnt == 2'd2);
        res2.last = (cnt == 2'd3);
        o_batch.tok[0] = res0;
        o_batch.tok[1] = res1;
        o_batch.tok[2] = res2;
        o_batch.cnt    = cnt;

        if (fin) begin
            n_mode  = M_IDLE;
            n_pos   = '0;
            n_start = '0;
            n_hex   = 2'd0;
            n_lidx  = 2'd0;
            n_lwh   = L_TRUE;
        end else begin
            n_mode  = m1;
            n_pos   = r_pos + POS_W'(1);
            n_start = s1;
            n_hex   = hex1;
            n_lidx  = lidx1;
            n_lwh   = lwh1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_pos   <= '0;
            r_start <= '0;
            r_hex   <= 2'd0;
            r_lidx  <= 2'd0;
            r_lwh   <= L_TRUE;
        end else if (i_adv) begin
            r_mode  <= n_mode;
            r_pos   <= n_pos;
            r_start <= n_start;
            r_hex   <= n_hex;
            r_lidx  <= n_lidx;
            r_lwh   <= n_lwh;
        end
    end

endmodule

>>> design/jtl_outq.sv
// Three-entry result register that hands out one token item per cycle while o_tok is ready.
module jtl_outq import jtl_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_batch    i_batch,
    output logic      o_free,
    jtl_tok_if.source o_tok
);

    t_tok [2:0] r_ent;
    logic [1:0] r_cnt;
    logic       pop;

    assign pop    = (r_cnt != 2'd0) && o_tok.ready;
    assign o_free = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && pop);

    assign o_tok.valid        = (r_cnt != 2'd0);
    assign o_tok.token_kind   = r_ent[0].kind;
    assign o_tok.token_offset = r_ent[0].offset;
    assign o_tok.token_length = r_ent[0].length;
    assign o_tok.run_last     = r_ent[0].last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_batch.cnt;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ent <= i_batch.tok;
        end else if (pop) begin
            r_ent[0] <= r_ent[1];
            r_ent[1] <= r_ent[2];
        end
    end

endmodule

>>> design/json_token_lexer.sv
// Top level of the streaming JSON token lexer.
//
//  channel  dir  payload                                             handshake
//  i_src    in   source_byte[7:0], final_byte                        valid/ready
//  o_tok    out  token_kind[3:0], token_offset[19:0],                valid/ready
//                token_length[20:0], run_last
//
// One byte per cycle while each byte yields at most one token and o_tok is ready; a
// byte yielding n tokens holds the input while the one-token-per-cycle result
// register drains. Bytes wait in the input register, tokens in the result register.
// Synchronous active-low reset clears the lexer state, input and result valids.
// Output stalls back up through the result register into the input register.
module json_token_lexer import jtl_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    jtl_src_if.sink   i_src,
    jtl_tok_if.source o_tok
);

    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_fin;
    logic       q_free;
    logic       adv;
    t_batch     batch;

    assign adv         = r_in_valid && q_free;
    assign i_src.ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_src.valid && i_src.ready) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_src.valid && i_src.ready) begin
            r_byte <= i_src.source_byte;
            r_fin  <= i_src.final_byte;
        end
    end

    jtl_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_byte  (r_byte),
        .i_fin   (r_fin),
        .o_batch (batch)
    );

    jtl_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (adv),
        .i_batch (batch),
        .o_free  (q_free),
        .o_tok   (o_tok)
    );

endmodule
